/* src/sbt_pkg.sv */
// Shared types, codes and constants of the sorted byte table.
package sbt_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned DefDepth = 64;
  localparam int unsigned ValW     = 8;
  localparam int unsigned PosW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e                 status;
    logic [PosW-1:0]         found_position;
    logic signed [ValW-1:0]  read_value;
    logic [CntW-1:0]         fill_count;
  } res_t;

  // True when a new value belongs in front of entry e under the given order.
  function automatic logic goes_before(input logic desc, input logic signed [ValW-1:0] v,
                                       input logic signed [ValW-1:0] e);
    return desc ? (v > e) : (v < e);
  endfunction

endpackage

/* src/sorted_byte_table_core.sv */
// Sorted byte table: top level with mode register, entry memory and result register.
//
// The block keeps up to DEPTH signed bytes sorted ascending or descending and
// answers one request at a time; each request gives one response. All work
// goes through the single read port of the entry memory. Insert, delete and
// read walk the entries one a cycle: an insert reads every held entry and
// shifts the tail up in the same pass, a delete reads from the position to
// the end and shifts the tail down, and a read reads one entry. A search
// probes the range midpoint until a hit or an empty range. A new request
// is taken as soon as the previous response sits in the output register,
// even while that response still waits on the downstream side. The mode
// register may be written only while no request is in flight; entries held
// are not re-sorted when it changes.
module sorted_byte_table_core #(
  parameter int unsigned DEPTH = sbt_pkg::DefDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Mode register.
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,     // sort_descending
  // Request stream.
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [sbt_pkg::InDataW-1:0]  s_tdata_i,       // value[7:0], position[13:8]
  input  logic [sbt_pkg::OpW-1:0]      s_tuser_i,       // opcode[1:0]
  // Response stream.
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [sbt_pkg::OutDataW-1:0] m_tdata_o,       // found_position[5:0],
                                                        // read_value[13:6],
                                                        // fill_count[20:14]
  output logic [sbt_pkg::StatW-1:0]    m_tuser_o        // status[1:0]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                            desc_q;
  logic                            res_valid;
  logic                            res_ready;
  sbt_pkg::res_t                   res;
  logic                            m_valid_q, m_valid_d;
  sbt_pkg::res_t                   m_res_q;

  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic signed [sbt_pkg::ValW-1:0] mem_rdata;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic signed [sbt_pkg::ValW-1:0] mem_wdata;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
    end else if (cfg_we_i) begin
      desc_q <= cfg_wdata_i;
    end
  end

  sbt_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  sbt_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .desc_i     (desc_q),
    .req_valid_i(s_tvalid_i),
    .req_ready_o(s_tready_o),
    .req_op_i   (sbt_pkg::op_e'(s_tuser_i)),
    .req_value_i(s_tdata_i[7:0]),
    .req_pos_i  (s_tdata_i[13:8]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata)
  );

  // Output register: takes a new response when empty or being drained.
  assign res_ready = !m_valid_q || m_tready_i;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = m_res_q.status;
  assign m_tdata_o  = {3'b000, m_res_q.fill_count, m_res_q.read_value,
                       m_res_q.found_position};

endmodule

/* src/sbt_mem.sv */
// Entry storage: one write port and one read port with registered read data.
module sbt_mem #(
  parameter int unsigned DEPTH = sbt_pkg::DefDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic signed [sbt_pkg::ValW-1:0] wdata_i,
  input  logic                            re_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic signed [sbt_pkg::ValW-1:0] rdata_o
);

  logic signed [sbt_pkg::ValW-1:0] mem_q [DEPTH];
  logic signed [sbt_pkg::ValW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sbt_ctrl.sv */
// Operation sequencer: walks the entry memory for insert, delete, read and search.
module sbt_ctrl #(
  parameter int unsigned DEPTH = sbt_pkg::DefDepth,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            desc_i,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  sbt_pkg::op_e                    req_op_i,
  input  logic signed [sbt_pkg::ValW-1:0] req_value_i,
  input  logic [sbt_pkg::PosW-1:0]        req_pos_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output sbt_pkg::res_t                   res_o,
  output logic                            mem_re_o,
  output logic [AW-1:0]                   mem_raddr_o,
  input  logic signed [sbt_pkg::ValW-1:0] mem_rdata_i,
  output logic                            mem_we_o,
  output logic [AW-1:0]                   mem_waddr_o,
  output logic signed [sbt_pkg::ValW-1:0] mem_wdata_o
);

  sbt_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            found_q, found_d;

  sbt_pkg::op_e                    op_q, op_d;
  logic signed [sbt_pkg::ValW-1:0] val_q, val_d;
  logic [sbt_pkg::PosW-1:0]        pos_q, pos_d;
  logic [CW-1:0]                   idx_q, idx_d;
  logic [CW-1:0]                   lim_q, lim_d;
  logic [AW-1:0]                   pend_idx_q, pend_idx_d;
  logic [AW-1:0]                   hit_q, hit_d;
  logic signed [sbt_pkg::ValW-1:0] carry_q, carry_d;
  logic signed [sbt_pkg::ValW-1:0] got_q, got_d;
  logic [CW-1:0]                   lo_q, lo_d;
  logic [CW-1:0]                   hiex_q, hiex_d;
  logic [CW-1:0]                   mid_q, mid_d;
  sbt_pkg::res_t                   res_q, res_d;

  logic            issue;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   cnt_inc;
  logic [CW-1:0]   cnt_dec;

  assign cnt_inc = cnt_q + 1'b1;
  assign cnt_dec = cnt_q - 1'b1;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hiex_q} - 1'b1;

  // Next state, memory accesses and result capture.
  // During a walk the write always lands below the address being read, so
  // the two ports never meet on one entry and no forwarding is needed.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    found_d     = found_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    carry_d     = carry_q;
    got_d       = got_q;
    lo_d        = lo_q;
    hiex_d      = hiex_q;
    mid_d       = mid_q;
    res_d       = res_q;
    issue       = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[AW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = pend_idx_q;
    mem_wdata_o = val_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      sbt_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d    = req_op_i;
          val_d   = req_value_i;
          pos_d   = req_pos_i;
          pend_d  = 1'b0;
          found_d = 1'b0;
          lo_d    = '0;
          hiex_d  = cnt_q;
          idx_d   = '0;
          lim_d   = cnt_q;
          unique case (req_op_i)
            sbt_pkg::OP_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                res_d   = '{sbt_pkg::STATUS_FULL, '0, '0, sbt_pkg::CntW'(cnt_q)};
                state_d = sbt_pkg::S_DONE;
              end else begin
                state_d = sbt_pkg::S_WALK;
              end
            end
            sbt_pkg::OP_DELETE, sbt_pkg::OP_READ: begin
              if (int'(req_pos_i) >= int'(cnt_q)) begin
                res_d   = '{sbt_pkg::STATUS_RANGE, '0, '0, sbt_pkg::CntW'(cnt_q)};
                state_d = sbt_pkg::S_DONE;
              end else begin
                idx_d   = CW'(req_pos_i);
                lim_d   = (req_op_i == sbt_pkg::OP_READ) ? CW'(req_pos_i) + 1'b1 : cnt_q;
                state_d = sbt_pkg::S_WALK;
              end
            end
            sbt_pkg::OP_SEARCH: begin
              state_d = sbt_pkg::S_SRCH_RD;
            end
            default: ;
          endcase
        end
      end

      sbt_pkg::S_WALK: begin
        // Read side: one entry a cycle up to the limit.
        issue       = idx_q < lim_q;
        mem_re_o    = issue;
        mem_raddr_o = idx_q[AW-1:0];
        pend_d      = issue;
        pend_idx_d  = idx_q[AW-1:0];
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end

        // Data side: act on the entry read in the previous cycle.
        if (pend_q) begin
          unique case (op_q)
            sbt_pkg::OP_INSERT: begin
              if (found_q) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = carry_q;
                carry_d     = mem_rdata_i;
              end else if (sbt_pkg::goes_before(desc_i, val_q, mem_rdata_i)) begin
                mem_we_o    = 1'b1;
                mem_wdata_o = val_q;
                found_d     = 1'b1;
                hit_d       = pend_idx_q;
                carry_d     = mem_rdata_i;
              end
            end
            sbt_pkg::OP_DELETE: begin
              if (int'(pend_idx_q) == int'(pos_q)) begin
                got_d = mem_rdata_i;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = pend_idx_q - 1'b1;
                mem_wdata_o = mem_rdata_i;
              end
            end
            sbt_pkg::OP_READ: begin
              got_d = mem_rdata_i;
            end
            default: ;
          endcase
        end

        // Wrap-up once every read has drained.
        if (!issue && !pend_q) begin
          state_d = sbt_pkg::S_DONE;
          unique case (op_q)
            sbt_pkg::OP_INSERT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = cnt_q[AW-1:0];
              mem_wdata_o = found_q ? carry_q : val_q;
              cnt_d       = cnt_inc;
              res_d       = '{sbt_pkg::STATUS_OK,
                              found_q ? sbt_pkg::PosW'(hit_q) : sbt_pkg::PosW'(cnt_q),
                              '0, sbt_pkg::CntW'(cnt_inc)};
            end
            sbt_pkg::OP_DELETE: begin
              cnt_d = cnt_dec;
              res_d = '{sbt_pkg::STATUS_OK, pos_q, got_q, sbt_pkg::CntW'(cnt_dec)};
            end
            default: begin
              res_d = '{sbt_pkg::STATUS_OK, pos_q, got_q, sbt_pkg::CntW'(cnt_q)};
            end
          endcase
        end
      end

      sbt_pkg::S_SRCH_RD: begin
        // Probe the midpoint of the open range, or give up when it is empty.
        if (lo_q < hiex_q) begin
          mid_d       = mid_sum[CW:1];
          mem_re_o    = 1'b1;
          mem_raddr_o = mid_sum[AW:1];
          state_d     = sbt_pkg::S_SRCH_CMP;
        end else begin
          res_d   = '{sbt_pkg::STATUS_NOT_FOUND, '0, '0, sbt_pkg::CntW'(cnt_q)};
          state_d = sbt_pkg::S_DONE;
        end
      end

      sbt_pkg::S_SRCH_CMP: begin
        if (mem_rdata_i == val_q) begin
          res_d   = '{sbt_pkg::STATUS_OK, sbt_pkg::PosW'(mid_q), '0, sbt_pkg::CntW'(cnt_q)};
          state_d = sbt_pkg::S_DONE;
        end else begin
          if (desc_i ? (mem_rdata_i < val_q) : (mem_rdata_i > val_q)) begin
            hiex_d = mid_q;
          end else begin
            lo_d = mid_q + 1'b1;
          end
          state_d = sbt_pkg::S_SRCH_RD;
        end
      end

      sbt_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sbt_pkg::S_IDLE;
        end
      end

      default: state_d = sbt_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbt_pkg::S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    lim_q      <= lim_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    carry_q    <= carry_d;
    got_q      <= got_d;
    lo_q       <= lo_d;
    hiex_q     <= hiex_d;
    mid_q      <= mid_d;
    res_q      <= res_d;
  end

  assign res_o = res_q;

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("fill count above depth");

  // Read and write never touch the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (mem_re_o && mem_we_o) |-> (mem_raddr_o != mem_waddr_o))
    else $error("read and write collide on one entry");

  // The fill count only moves at the end of a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q != $past(cnt_q)) |-> ($past(state_q) == sbt_pkg::S_WALK))
    else $error("fill count changed outside a walk");

  // No read is left in flight once the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == sbt_pkg::S_IDLE) |-> !pend_q)
    else $error("pending read in idle state");

endmodule
